@@ hw/rtl/arcit_pkg.sv @@
// Shared types, codes and helpers for the alert root-cause inhibit table.
`timescale 1ns / 1ps

package arcit_pkg;

    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 16;
    localparam int EVENT_W  = 3;
    localparam int COUNT_W  = 6;
    localparam int TAIL_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RAISE     = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_CLEAR_ALL = 2'd2,
        ACT_QUERY     = 2'd3
    } action_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_INHIBITED = 3'd0,
        EV_ACTIVE    = 3'd1,
        EV_DETECTED  = 3'd2,
        EV_CHANGED   = 3'd3,
        EV_COUNTS    = 3'd4,
        EV_FULL      = 3'd5
    } event_t;

    // Trailing results still to send, lowest bit first
    localparam logic [TAIL_W-1:0] TL_ACTIVE  = 5'b00001;
    localparam logic [TAIL_W-1:0] TL_DETECT  = 5'b00010;
    localparam logic [TAIL_W-1:0] TL_CHANGED = 5'b00100;
    localparam logic [TAIL_W-1:0] TL_COUNTS  = 5'b01000;
    localparam logic [TAIL_W-1:0] TL_FULL    = 5'b10000;

    // Lookup results gathered over one sweep of the table
    typedef struct packed {
        logic hit;
        logic hit_inh;
        logic hit_sym;
        logic hit_match;
        logic root_hit;
        logic root_inh;
    } scan_flags_t;

    function automatic event_t tail_code(input logic [TAIL_W-1:0] pick);
        event_t ev;
        case (pick)
            TL_ACTIVE:  ev = EV_ACTIVE;
            TL_DETECT:  ev = EV_DETECTED;
            TL_CHANGED: ev = EV_CHANGED;
            TL_COUNTS:  ev = EV_COUNTS;
            TL_FULL:    ev = EV_FULL;
            default:    ev = EV_COUNTS;
        endcase
        return ev;
    endfunction

endpackage

@@ hw/rtl/alert_root_cause_inhibit_table_core.sv @@
// Top level: sequencer, entry memory, sweep checker and result register.
// Raise and clear sweep the table through the single read port of the entry
// memory and decide; unless a clear finds its key absent, each reported
// symptom is then read and written back and the trailing results are sent.
// Clear-all and query send one trailing result. One item at a time: a new
// item is taken only when the last is through, and output stalls hold the
// reporting states. Reset clears valid bits, counts and control at once;
// entry memory contents are never cleared.
`timescale 1ns / 1ps

module alert_root_cause_inhibit_table_core #(
    parameter int TABLE_ENTRIES = 32,
    parameter int KEY_BITS      = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [arcit_pkg::ACTION_W-1:0]     action,
    input  logic [arcit_pkg::FIELD_W-1:0]      alert_key,
    input  logic                               has_root,
    input  logic [arcit_pkg::FIELD_W-1:0]      root_key,
    input  logic [arcit_pkg::FIELD_W-1:0]      severity_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [arcit_pkg::EVENT_W-1:0]      event_res,
    output logic [arcit_pkg::FIELD_W-1:0]      event_key,
    output logic [arcit_pkg::FIELD_W-1:0]      event_severity,
    output logic [arcit_pkg::COUNT_W-1:0]      alert_count,
    output logic [arcit_pkg::COUNT_W-1:0]      inhibited_total,
    output logic                               last_result
);

    localparam int N  = TABLE_ENTRIES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int SW = CW + 1;
    // Keys arrive on 16-bit ports, so at most 16 bits take part
    localparam int KW = (KEY_BITS < arcit_pkg::FIELD_W) ? KEY_BITS : arcit_pkg::FIELD_W;
    localparam int SEVW = arcit_pkg::FIELD_W;

    // Entry word layout: key | root | symptom | inhibited | severity
    localparam int INH_BIT = SEVW;
    localparam int SYM_BIT = SEVW + 1;
    localparam int ROOT_LO = SEVW + 2;
    localparam int KEY_LO  = ROOT_LO + KW;
    localparam int EW      = KEY_LO + KW;

    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_RD,
        ST_WR,
        ST_TAIL
    } state_t;

    // Lowest set bit of a slot vector
    function automatic logic [IW-1:0] low_idx(input logic [N-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    // Sequencer and item hold
    state_t                          state_reg, state_next;
    arcit_pkg::action_t              act_reg, act_next;
    logic [KW-1:0]                   key_reg, key_next;
    logic [KW-1:0]                   root_reg, root_next;
    logic                            sym_reg, sym_next;
    logic [SEVW-1:0]                 sev_reg, sev_next;
    logic [IW-1:0]                   scan_idx_reg, scan_idx_next;
    logic                            chk_vld_reg, chk_vld_next;
    logic [IW-1:0]                   chk_idx_reg, chk_idx_next;
    logic [IW-1:0]                   wr_idx_reg, wr_idx_next;
    logic [arcit_pkg::TAIL_W-1:0]    tail_reg, tail_next;
    logic [KW-1:0]                   tail_key_reg, tail_key_next;

    // Table bookkeeping
    logic [N-1:0]                    valid_reg, valid_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [CW-1:0]                   tally_reg, tally_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    arcit_pkg::event_t               out_ev_reg, out_ev_next;
    logic [arcit_pkg::FIELD_W-1:0]   out_key_reg, out_key_next;
    logic [SEVW-1:0]                 out_sev_reg, out_sev_next;
    logic [CW-1:0]                   out_cnt_reg, out_cnt_next;
    logic [CW-1:0]                   out_inh_reg, out_inh_next;
    logic                            out_last_reg, out_last_next;

    // Memory port and checker controls
    logic                            mem_we;
    logic [IW-1:0]                   mem_waddr;
    logic [EW-1:0]                   mem_wdata;
    logic [IW-1:0]                   mem_raddr;
    logic [EW-1:0]                   mem_rdata;
    logic                            scan_start;
    logic                            clr_en;
    logic [IW-1:0]                   clr_idx;
    logic                            clr_all;
    logic [N-1:0]                    match_vec;
    logic [CW-1:0]                   match_cnt;
    logic [IW-1:0]                   hit_idx;
    arcit_pkg::scan_flags_t          scan_flags;

    // Decision helpers
    logic                            can_load;
    logic                            out_load;
    logic                            is_raise;
    logic [IW-1:0]                   free_idx;
    logic                            free_ok;
    logic [IW-1:0]                   slot;
    logic                            new_inh;
    logic [SW-1:0]                   nm;
    logic [SW-1:0]                   t1;
    logic [SW-1:0]                   t2;
    logic [SW-1:0]                   t3;
    logic [IW-1:0]                   sel_idx;
    logic [arcit_pkg::TAIL_W-1:0]    tail_pick;
    logic [arcit_pkg::TAIL_W-1:0]    tail_left;

    assign can_load = !out_valid_reg || out_ready;
    assign is_raise = (act_reg == arcit_pkg::ACT_RAISE);
    assign free_idx = low_idx(~valid_reg);
    assign free_ok  = |(~valid_reg);
    assign sel_idx  = low_idx(match_vec);
    assign slot     = scan_flags.hit ? hit_idx : free_idx;
    // A symptom starts inhibited when its root is held and not itself inhibited
    assign new_inh  = sym_reg && scan_flags.root_hit && !scan_flags.root_inh;

    // Lowest pending trailing result
    always_comb
    begin
        tail_pick = '0;
        for (int b = arcit_pkg::TAIL_W - 1; b >= 0; b--)
        begin
            if (tail_reg[b])
            begin
                tail_pick = arcit_pkg::TAIL_W'(1) << b;
            end
        end
    end
    assign tail_left = tail_reg & ~tail_pick;

    arcit_mem #(
        .DEPTH (N),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    arcit_scan #(
        .N  (N),
        .KW (KW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .chk_vld   (chk_vld_reg),
        .chk_idx   (chk_idx_reg),
        .ent_valid (valid_reg[chk_idx_reg]),
        .ent_key   (mem_rdata[KEY_LO +: KW]),
        .ent_root  (mem_rdata[ROOT_LO +: KW]),
        .ent_sym   (mem_rdata[SYM_BIT]),
        .ent_inh   (mem_rdata[INH_BIT]),
        .is_raise  (is_raise),
        .item_key  (key_reg),
        .item_root (root_reg),
        .item_sym  (sym_reg),
        .clr_en    (clr_en),
        .clr_idx   (clr_idx),
        .clr_all   (clr_all),
        .match_vec (match_vec),
        .match_cnt (match_cnt),
        .hit_idx   (hit_idx),
        .flags     (scan_flags)
    );

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        root_next      = root_reg;
        sym_next       = sym_reg;
        sev_next       = sev_reg;
        scan_idx_next  = scan_idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        wr_idx_next    = wr_idx_reg;
        tail_next      = tail_reg;
        tail_key_next  = tail_key_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ev_next    = out_ev_reg;
        out_key_next   = out_key_reg;
        out_sev_next   = out_sev_reg;
        out_cnt_next   = out_cnt_reg;
        out_inh_next   = out_inh_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = slot;
        mem_wdata      = mem_rdata;
        mem_raddr      = scan_idx_reg;
        scan_start     = 1'b0;
        clr_en         = 1'b0;
        clr_idx        = hit_idx;
        clr_all        = 1'b0;
        nm             = '0;
        t1             = '0;
        t2             = '0;
        t3             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = arcit_pkg::action_t'(action);
                    key_next  = alert_key[KW-1:0];
                    root_next = root_key[KW-1:0];
                    sym_next  = has_root;
                    sev_next  = severity_in;
                    case (arcit_pkg::action_t'(action))
                        arcit_pkg::ACT_RAISE,
                        arcit_pkg::ACT_CLEAR:
                        begin
                            scan_start    = 1'b1;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        arcit_pkg::ACT_CLEAR_ALL:
                        begin
                            // Drop every entry at once
                            valid_next    = '0;
                            cnt_next      = '0;
                            tally_next    = '0;
                            tail_next     = arcit_pkg::TL_CHANGED;
                            tail_key_next = '0;
                            state_next    = ST_TAIL;
                        end
                        default:
                        begin
                            tail_next     = arcit_pkg::TL_COUNTS;
                            tail_key_next = '0;
                            state_next    = ST_TAIL;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; the checker sees it in the next cycle
                mem_raddr    = scan_idx_reg;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (is_raise)
                begin
                    if (!scan_flags.hit && !free_ok)
                    begin
                        tail_next     = arcit_pkg::TL_FULL;
                        tail_key_next = key_reg;
                        state_next    = ST_TAIL;
                    end
                    else
                    begin
                        // The replaced slot never reports itself
                        nm = SW'(match_cnt) - SW'(scan_flags.hit_match);
                        t1 = SW'(tally_reg) + nm;
                        t2 = (scan_flags.hit && scan_flags.hit_inh && (t1 != '0)) ?
                             t1 - 1'b1 : t1;
                        t3 = t2 + SW'(new_inh);
                        tally_next = CW'(t3);
                        cnt_next   = scan_flags.hit ? cnt_reg : cnt_reg + 1'b1;
                        clr_en     = scan_flags.hit && scan_flags.hit_match;
                        clr_idx    = hit_idx;
                        mem_we     = 1'b1;
                        mem_waddr  = slot;
                        mem_wdata  = {key_reg, (sym_reg ? root_reg : {KW{1'b0}}),
                                      sym_reg, new_inh, sev_reg};
                        valid_next[slot] = 1'b1;
                        tail_next     = arcit_pkg::TL_CHANGED |
                                        (sym_reg ? '0 : arcit_pkg::TL_DETECT) |
                                        (new_inh ? '0 : arcit_pkg::TL_ACTIVE);
                        tail_key_next = key_reg;
                        state_next    = ST_RD;
                    end
                end
                else if (scan_flags.hit)
                begin
                    // Clearing a symptom releases nothing
                    nm = scan_flags.hit_sym ? '0 :
                         SW'(match_cnt) - SW'(scan_flags.hit_match);
                    t1 = (scan_flags.hit_inh && (tally_reg != '0)) ?
                         SW'(tally_reg) - 1'b1 : SW'(tally_reg);
                    t2 = (t1 >= nm) ? t1 - nm : '0;
                    tally_next = CW'(t2);
                    cnt_next   = cnt_reg - 1'b1;
                    clr_all    = scan_flags.hit_sym;
                    clr_en     = scan_flags.hit_match;
                    clr_idx    = hit_idx;
                    valid_next[hit_idx] = 1'b0;
                    tail_next     = arcit_pkg::TL_CHANGED;
                    tail_key_next = key_reg;
                    state_next    = ST_RD;
                end
                else
                begin
                    // Absent key: no change, no result
                    state_next = ST_IDLE;
                end
            end

            ST_RD:
            begin
                if (|match_vec)
                begin
                    mem_raddr   = sel_idx;
                    wr_idx_next = sel_idx;
                    state_next  = ST_WR;
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end

            ST_WR:
            begin
                // Hold the read address so the data stays while stalled
                mem_raddr = wr_idx_reg;
                if (can_load)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_ev_next    = is_raise ? arcit_pkg::EV_INHIBITED :
                                                arcit_pkg::EV_ACTIVE;
                    out_key_next   = arcit_pkg::FIELD_W'(mem_rdata[KEY_LO +: KW]);
                    out_sev_next   = '0;
                    out_cnt_next   = cnt_reg;
                    out_inh_next   = tally_reg;
                    out_last_next  = 1'b0;
                    mem_we         = 1'b1;
                    mem_waddr      = wr_idx_reg;
                    mem_wdata      = mem_rdata;
                    mem_wdata[INH_BIT] = is_raise;
                    clr_en         = 1'b1;
                    clr_idx        = wr_idx_reg;
                    state_next     = ST_RD;
                end
            end

            ST_TAIL:
            begin
                if (can_load)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_ev_next    = arcit_pkg::tail_code(tail_pick);
                    out_key_next   = arcit_pkg::FIELD_W'(tail_key_reg);
                    out_sev_next   = (tail_pick == arcit_pkg::TL_DETECT) ? sev_reg : '0;
                    out_cnt_next   = cnt_reg;
                    out_inh_next   = tally_reg;
                    out_last_next  = (tail_left == '0);
                    tail_next      = tail_left;
                    if (tail_left == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= arcit_pkg::ACT_QUERY;
            key_reg       <= '0;
            root_reg      <= '0;
            sym_reg       <= 1'b0;
            sev_reg       <= '0;
            scan_idx_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            wr_idx_reg    <= '0;
            tail_reg      <= '0;
            tail_key_reg  <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= arcit_pkg::EV_COUNTS;
            out_key_reg   <= '0;
            out_sev_reg   <= '0;
            out_cnt_reg   <= '0;
            out_inh_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            key_reg       <= key_next;
            root_reg      <= root_next;
            sym_reg       <= sym_next;
            sev_reg       <= sev_next;
            scan_idx_reg  <= scan_idx_next;
            chk_vld_reg   <= chk_vld_next;
            chk_idx_reg   <= chk_idx_next;
            wr_idx_reg    <= wr_idx_next;
            tail_reg      <= tail_next;
            tail_key_reg  <= tail_key_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            out_ev_reg    <= out_ev_next;
            out_key_reg   <= out_key_next;
            out_sev_reg   <= out_sev_next;
            out_cnt_reg   <= out_cnt_next;
            out_inh_reg   <= out_inh_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Take a new item only between items; a pending result transfer
    // does not block acceptance
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign event_res       = out_ev_reg;
    assign event_key       = out_key_reg;
    assign event_severity  = out_sev_reg;
    assign alert_count     = arcit_pkg::COUNT_W'(out_cnt_reg);
    assign inhibited_total = arcit_pkg::COUNT_W'(out_inh_reg);
    assign last_result     = out_last_reg;

    // Inhibited entries are always a subset of the held entries
    a_tally_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= cnt_reg)
        else $error("inhibited tally exceeds alert count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(N))
        else $error("alert count beyond table size");

    a_release_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && out_load) |-> valid_reg[wr_idx_reg])
        else $error("symptom update hits an empty slot");

    a_check_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("lookup check outside the sweep");

    a_clear_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && act_reg == arcit_pkg::ACT_CLEAR && scan_flags.hit)
        |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("clear did not drop exactly one entry");

endmodule

@@ hw/rtl/arcit_mem.sv @@
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module arcit_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/arcit_scan.sv @@
// Sweep checker: key lookup, root lookup and symptom match vector.
`timescale 1ns / 1ps

module arcit_scan #(
    parameter int N  = 32,
    parameter int KW = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      chk_vld,
    input  logic [$clog2(N)-1:0]      chk_idx,
    input  logic                      ent_valid,
    input  logic [KW-1:0]             ent_key,
    input  logic [KW-1:0]             ent_root,
    input  logic                      ent_sym,
    input  logic                      ent_inh,
    input  logic                      is_raise,
    input  logic [KW-1:0]             item_key,
    input  logic [KW-1:0]             item_root,
    input  logic                      item_sym,
    input  logic                      clr_en,
    input  logic [$clog2(N)-1:0]      clr_idx,
    input  logic                      clr_all,
    output logic [N-1:0]              match_vec,
    output logic [$clog2(N+1)-1:0]    match_cnt,
    output logic [$clog2(N)-1:0]      hit_idx,
    output arcit_pkg::scan_flags_t    flags
);

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]           match_vec_reg, match_vec_next;
    logic [CW-1:0]          match_cnt_reg, match_cnt_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    arcit_pkg::scan_flags_t flags_reg, flags_next;
    logic                   match;

    // Symptom naming the item key: a root raise takes uninhibited ones,
    // a clear takes inhibited ones
    assign match = ent_valid && ent_sym && (ent_root == item_key) &&
                   (is_raise ? (!item_sym && !ent_inh) : ent_inh);

    always_comb
    begin
        match_vec_next = match_vec_reg;
        match_cnt_next = match_cnt_reg;
        hit_idx_next   = hit_idx_reg;
        flags_next     = flags_reg;
        if (start)
        begin
            match_vec_next = '0;
            match_cnt_next = '0;
            flags_next     = '0;
        end
        else if (chk_vld)
        begin
            if (match)
            begin
                match_vec_next[chk_idx] = 1'b1;
                match_cnt_next = match_cnt_reg + 1'b1;
            end
            if (ent_valid && (ent_key == item_key))
            begin
                hit_idx_next         = chk_idx;
                flags_next.hit       = 1'b1;
                flags_next.hit_inh   = ent_inh;
                flags_next.hit_sym   = ent_sym;
                flags_next.hit_match = match;
            end
            if (ent_valid && (ent_key == item_root))
            begin
                flags_next.root_hit = 1'b1;
                flags_next.root_inh = ent_inh;
            end
        end
        else if (clr_all)
        begin
            match_vec_next = '0;
        end
        else if (clr_en)
        begin
            match_vec_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_vec_reg <= '0;
            match_cnt_reg <= '0;
            hit_idx_reg   <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            match_vec_reg <= match_vec_next;
            match_cnt_reg <= match_cnt_next;
            hit_idx_reg   <= hit_idx_next;
            flags_reg     <= flags_next;
        end
    end

    assign match_vec = match_vec_reg;
    assign match_cnt = match_cnt_reg;
    assign hit_idx   = hit_idx_reg;
    assign flags     = flags_reg;

endmodule

@@ test/tb_alert_root_cause_inhibit_table_core.sv @@
// Self-checking testbench for the alert root-cause inhibit table core.
`timescale 1ns / 1ps

module tb_alert_root_cause_inhibit_table_core;

    localparam int TABLE_ENTRIES = 32;
    localparam int KEY_BITS      = 16;
    localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer on either side
    localparam int PHASE_ITEMS   = 80;
    localparam int SHOWN_ERRORS  = 10;

    // One result transfer as seen on the output side
    typedef struct packed {
        arcit_pkg::event_t                  res;
        logic [arcit_pkg::FIELD_W-1:0]      key;
        logic [arcit_pkg::FIELD_W-1:0]      sev;
        logic [arcit_pkg::COUNT_W-1:0]      count;
        logic [arcit_pkg::COUNT_W-1:0]      inh_total;
        logic                               last;
    } alert_event_t;

    // One row of the directed stimulus; gold_on marks a hand-typed expectation
    typedef struct packed {
        arcit_pkg::action_t                 act;
        logic [arcit_pkg::FIELD_W-1:0]      key;
        logic                               hr;
        logic [arcit_pkg::FIELD_W-1:0]      rk;
        logic [arcit_pkg::FIELD_W-1:0]      sev;
        logic                               gold_on;
        alert_event_t                       gold;
    } stim_row_t;

    localparam alert_event_t NO_GOLD = '0;
    localparam int N_DIRECTED = 19;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [arcit_pkg::ACTION_W-1:0]     action = arcit_pkg::ACT_QUERY;
    logic [arcit_pkg::FIELD_W-1:0]      alert_key = '0;
    logic                               has_root = 1'b0;
    logic [arcit_pkg::FIELD_W-1:0]      root_key = '0;
    logic [arcit_pkg::FIELD_W-1:0]      severity_in = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [arcit_pkg::EVENT_W-1:0]      event_res;
    logic [arcit_pkg::FIELD_W-1:0]      event_key;
    logic [arcit_pkg::FIELD_W-1:0]      event_severity;
    logic [arcit_pkg::COUNT_W-1:0]      alert_count;
    logic [arcit_pkg::COUNT_W-1:0]      inhibited_total;
    logic                               last_result;

    // Hand-typed expectation that travels with the item on the input port
    logic                               cur_gold_on = 1'b0;
    alert_event_t                       cur_gold = '0;

    // Shadow copy of the alert table
    logic                               tbl_valid [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]                tbl_key   [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]                tbl_root  [TABLE_ENTRIES];
    logic                               tbl_sym   [TABLE_ENTRIES];
    logic                               tbl_inh   [TABLE_ENTRIES];
    logic [arcit_pkg::FIELD_W-1:0]      tbl_sev   [TABLE_ENTRIES];
    int                                 inh_tally;

    alert_event_t                       expected_events [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int full_hits = 0;
    int inhibit_hits = 0;
    int release_hits = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // query straight after reset: empty table
        '{arcit_pkg::ACT_QUERY,     16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b1,
          '{arcit_pkg::EV_COUNTS, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1}},
        // clear of an absent key: no result
        '{arcit_pkg::ACT_CLEAR,     16'h1234, 1'b0, 16'h0000, 16'h0000, 1'b0, NO_GOLD},
        // root at the top key, top severity
        '{arcit_pkg::ACT_RAISE,     16'hFFFF, 1'b0, 16'h0000, 16'hFFFF, 1'b0, NO_GOLD},
        // symptoms under a present root get inhibited
        '{arcit_pkg::ACT_RAISE,     16'h0000, 1'b1, 16'hFFFF, 16'h0000, 1'b0, NO_GOLD},
        '{arcit_pkg::ACT_RAISE,     16'h0001, 1'b1, 16'hFFFF, 16'h1111, 1'b0, NO_GOLD},
        // symptom whose root is absent stays active
        '{arcit_pkg::ACT_RAISE,     16'h0002, 1'b1, 16'h0010, 16'h2222, 1'b0, NO_GOLD},
        // late root inhibits the waiting symptom
        '{arcit_pkg::ACT_RAISE,     16'h0010, 1'b0, 16'h0000, 16'h8000, 1'b0, NO_GOLD},
        // re-raise an inhibited symptom under another root
        '{arcit_pkg::ACT_RAISE,     16'h0002, 1'b1, 16'hFFFF, 16'h3333, 1'b0, NO_GOLD},
        // re-raise a root: its own slot is skipped by the sweep
        '{arcit_pkg::ACT_RAISE,     16'hFFFF, 1'b0, 16'h0000, 16'h0001, 1'b0, NO_GOLD},
        // root present but itself inhibited: symptom stays active
        '{arcit_pkg::ACT_RAISE,     16'h0003, 1'b1, 16'h0000, 16'h4444, 1'b0, NO_GOLD},
        // symptom naming an active symptom gets inhibited
        '{arcit_pkg::ACT_RAISE,     16'h0004, 1'b1, 16'h0003, 16'h5555, 1'b0, NO_GOLD},
        // clear that symptom: its dependent keeps the inhibited mark
        '{arcit_pkg::ACT_CLEAR,     16'h0003, 1'b0, 16'h0000, 16'h0000, 1'b0, NO_GOLD},
        // self-named symptom, new then re-raised
        '{arcit_pkg::ACT_RAISE,     16'h0005, 1'b1, 16'h0005, 16'hAAAA, 1'b0, NO_GOLD},
        '{arcit_pkg::ACT_RAISE,     16'h0005, 1'b1, 16'h0005, 16'h5555, 1'b0, NO_GOLD},
        // clear a root with inhibited symptoms: they are released
        '{arcit_pkg::ACT_CLEAR,     16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0, NO_GOLD},
        // clear a root with nothing under it
        '{arcit_pkg::ACT_CLEAR,     16'h0010, 1'b0, 16'h0000, 16'h0000, 1'b0, NO_GOLD},
        // root with a stray root_key that must be ignored
        '{arcit_pkg::ACT_RAISE,     16'h0010, 1'b0, 16'hFFFF, 16'h0000, 1'b0, NO_GOLD},
        '{arcit_pkg::ACT_CLEAR_ALL, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
          '{arcit_pkg::EV_CHANGED, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1}},
        '{arcit_pkg::ACT_QUERY,     16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
          '{arcit_pkg::EV_COUNTS, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1}}
    };

    alert_root_cause_inhibit_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BITS(KEY_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .alert_key(alert_key),
        .has_root(has_root),
        .root_key(root_key),
        .severity_in(severity_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_res(event_res),
        .event_key(event_key),
        .event_severity(event_severity),
        .alert_count(alert_count),
        .inhibited_total(inhibited_total),
        .last_result(last_result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: stall at the rate of the current phase, drive on the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Shadow table
    // ---------------------------------------------------------------
    function automatic int lookup_slot(input logic [KEY_BITS-1:0] k);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic alert_event_t make_event(input arcit_pkg::event_t ev,
                                                input logic [15:0] k,
                                                input logic [15:0] sv);
        alert_event_t e;
        e = '0;
        e.res = ev;
        e.key = k;
        e.sev = sv;
        return e;
    endfunction

    // Apply one accepted item to the shadow table and queue the results it causes
    task automatic apply_alert_action(input arcit_pkg::action_t act, input logic [15:0] k,
                                      input logic hr, input logic [15:0] rk,
                                      input logic [15:0] sv);
        alert_event_t evs [$];
        alert_event_t e;
        int slot;
        int p;
        int live;
        logic inh;
        slot = lookup_slot(k);
        inh = 1'b0;
        case (act)
            arcit_pkg::ACT_RAISE:
            begin
                if (slot < 0)
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (!tbl_valid[i] && slot < 0)
                            slot = i;
                    end
                end
                if (slot < 0)
                begin
                    evs.push_back(make_event(arcit_pkg::EV_FULL, k, '0));
                end
                else
                begin
                    if (hr)
                    begin
                        // lookup sees the table before the write
                        p = lookup_slot(rk);
                        if (p >= 0 && !tbl_inh[p])
                            inh = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            if (i != slot && tbl_valid[i] && tbl_sym[i]
                                && tbl_root[i] == k && !tbl_inh[i])
                            begin
                                tbl_inh[i] = 1'b1;
                                inh_tally++;
                                evs.push_back(make_event(arcit_pkg::EV_INHIBITED,
                                                         tbl_key[i], '0));
                            end
                        end
                    end
                    if (tbl_valid[slot] && tbl_inh[slot] && inh_tally > 0)
                        inh_tally--;
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = k;
                    tbl_root[slot]  = hr ? rk : '0;
                    tbl_sym[slot]   = hr;
                    tbl_inh[slot]   = inh;
                    tbl_sev[slot]   = sv;
                    if (inh)
                        inh_tally++;
                    else
                        evs.push_back(make_event(arcit_pkg::EV_ACTIVE, k, '0));
                    if (!hr)
                        evs.push_back(make_event(arcit_pkg::EV_DETECTED, k, sv));
                    evs.push_back(make_event(arcit_pkg::EV_CHANGED, k, '0));
                end
            end
            arcit_pkg::ACT_CLEAR:
            begin
                if (slot >= 0)
                begin
                    if (tbl_inh[slot] && inh_tally > 0)
                        inh_tally--;
                    if (!tbl_sym[slot])
                    begin
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            if (i != slot && tbl_valid[i] && tbl_sym[i]
                                && tbl_root[i] == k && tbl_inh[i])
                            begin
                                tbl_inh[i] = 1'b0;
                                if (inh_tally > 0)
                                    inh_tally--;
                                evs.push_back(make_event(arcit_pkg::EV_ACTIVE,
                                                         tbl_key[i], '0));
                            end
                        end
                    end
                    tbl_valid[slot] = 1'b0;
                    tbl_inh[slot]   = 1'b0;
                    evs.push_back(make_event(arcit_pkg::EV_CHANGED, k, '0));
                end
            end
            arcit_pkg::ACT_CLEAR_ALL:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    tbl_valid[i] = 1'b0;
                    tbl_inh[i]   = 1'b0;
                end
                inh_tally = 0;
                evs.push_back(make_event(arcit_pkg::EV_CHANGED, '0, '0));
            end
            default:
            begin
                evs.push_back(make_event(arcit_pkg::EV_COUNTS, '0, '0));
            end
        endcase
        // counts reflect the table after the whole step
        live = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_valid[i])
                live++;
        end
        for (int i = 0; i < evs.size(); i++)
        begin
            e = evs[i];
            e.count     = live[arcit_pkg::COUNT_W-1:0];
            e.inh_total = inh_tally[arcit_pkg::COUNT_W-1:0];
            e.last      = (i == evs.size() - 1);
            expected_events.push_back(e);
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: check results, update the shadow on input transfers, watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        alert_event_t want;
        alert_event_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{arcit_pkg::event_t'(event_res), event_key, event_severity,
                        alert_count, inhibited_total, last_result};
                results_checked++;
                if (got.res == arcit_pkg::EV_FULL)
                    full_hits++;
                if (got.res == arcit_pkg::EV_INHIBITED)
                    inhibit_hits++;
                if (expected_events.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display({"ERROR: unexpected result res=%0d key=%h sev=%h",
                                  " cnt=%0d inh=%0d last=%0b"},
                                 got.res, got.key, got.sev, got.count, got.inh_total,
                                 got.last);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= SHOWN_ERRORS)
                        begin
                            $display({"ERROR: result %0d expected res=%0d key=%h",
                                      " sev=%h cnt=%0d inh=%0d last=%0b"},
                                     results_checked, want.res, want.key, want.sev,
                                     want.count, want.inh_total, want.last);
                            $display({"ERROR: result %0d actual   res=%0d key=%h",
                                      " sev=%h cnt=%0d inh=%0d last=%0b"},
                                     results_checked, got.res, got.key, got.sev,
                                     got.count, got.inh_total, got.last);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items_accepted++;
                if (arcit_pkg::action_t'(action) == arcit_pkg::ACT_CLEAR
                    && lookup_slot(alert_key) >= 0
                    && !tbl_sym[lookup_slot(alert_key)])
                    release_hits++;
                apply_alert_action(arcit_pkg::action_t'(action), alert_key, has_root,
                                   root_key, severity_in);
                // typed rows carry exactly one result: swap in the hand value
                if (cur_gold_on)
                begin
                    void'(expected_events.pop_back());
                    expected_events.push_back(cur_gold);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_events.size());
                $display("alert_root_cause_inhibit_table_core: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Present one item on the falling edge and hold it until the transfer
    task automatic send_item(input arcit_pkg::action_t act, input logic [15:0] k,
                             input logic hr, input logic [15:0] rk,
                             input logic [15:0] sv,
                             input logic gold_on, input alert_event_t gold);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        action      = act;
        alert_key   = k;
        has_root    = hr;
        root_key    = rk;
        severity_in = sv;
        cur_gold_on = gold_on;
        cur_gold    = gold;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Small key pool so keys collide, plus the extremes and the full range
    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(39));
        else if (r < 80)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom_range(16'hFFFF));
    endfunction

    // Key of a random live entry, or a pool key when the table is empty
    function automatic logic [15:0] held_key();
        logic [15:0] live [$];
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_valid[i])
                live.push_back(tbl_key[i]);
        end
        if (live.size() == 0)
            return pick_key();
        return live[$urandom_range(live.size() - 1)];
    endfunction

    function automatic logic [15:0] rand_sev();
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Root with a fan of symptoms, then a release, a clear of a held key or a root re-raise
    task automatic run_cascade(inout int budget);
        logic [15:0] cause;
        int fanout;
        logic cause_first;
        cause = pick_key();
        fanout = $urandom_range(1, 6);
        cause_first = $urandom_range(1);
        if (cause_first)
            send_item(arcit_pkg::ACT_RAISE, cause, 1'b0, 16'($urandom_range(16'hFFFF)),
                      rand_sev(), 1'b0, NO_GOLD);
        for (int j = 0; j < fanout; j++)
            send_item(arcit_pkg::ACT_RAISE, pick_key(), 1'b1, cause, rand_sev(),
                      1'b0, NO_GOLD);
        if (!cause_first)
            send_item(arcit_pkg::ACT_RAISE, cause, 1'b0, 16'h0000, rand_sev(),
                      1'b0, NO_GOLD);
        if ($urandom_range(3) == 0)
        begin
            send_item(arcit_pkg::ACT_QUERY, pick_key(), 1'b0, 16'h0000, 16'h0000,
                      1'b0, NO_GOLD);
            budget++;
        end
        case ($urandom_range(3))
            0, 1: send_item(arcit_pkg::ACT_CLEAR, cause, 1'b0, 16'h0000, 16'h0000,
                            1'b0, NO_GOLD);
            2:    send_item(arcit_pkg::ACT_CLEAR, held_key(), 1'b0, 16'h0000, 16'h0000,
                            1'b0, NO_GOLD);
            default: send_item(arcit_pkg::ACT_RAISE, cause, 1'b0, 16'h0000, rand_sev(),
                               1'b0, NO_GOLD);
        endcase
        budget += fanout + 2;
    endtask

    // Single unstructured item, raw fields
    task automatic run_noise(inout int budget);
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_item(arcit_pkg::ACT_RAISE, pick_key(), 1'($urandom_range(1)),
                      $urandom_range(1) ? held_key() : pick_key(), rand_sev(),
                      1'b0, NO_GOLD);
        else if (r < 80)
            send_item(arcit_pkg::ACT_CLEAR, $urandom_range(3) != 0 ? held_key() : pick_key(),
                      1'($urandom_range(1)), pick_key(), rand_sev(), 1'b0, NO_GOLD);
        else if (r < 87)
            send_item(arcit_pkg::ACT_CLEAR_ALL, pick_key(), 1'($urandom_range(1)),
                      pick_key(), rand_sev(), 1'b0, NO_GOLD);
        else
            send_item(arcit_pkg::ACT_QUERY, pick_key(), 1'($urandom_range(1)),
                      pick_key(), rand_sev(), 1'b0, NO_GOLD);
        budget++;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        int budget;
        int pick;
        logic [15:0] fill_base;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_inh[i]   = 1'b0;
        end
        inh_tally = 0;

        // hold reset, then release it on a falling edge
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows, no idling on either side
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].hr,
                      directed_rows[i].rk, directed_rows[i].sev,
                      directed_rows[i].gold_on, directed_rows[i].gold);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase

            if (phase == 0)
            begin
                // fill every slot with roots, then push one more new key
                send_item(arcit_pkg::ACT_CLEAR_ALL, 16'h0000, 1'b0, 16'h0000, 16'h0000,
                          1'b1,
                          '{arcit_pkg::EV_CHANGED, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b1});
                fill_base = 16'h0100;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    send_item(arcit_pkg::ACT_RAISE, fill_base + 16'(i), 1'b0, 16'h0000,
                              rand_sev(), 1'b0, NO_GOLD);
                send_item(arcit_pkg::ACT_RAISE, 16'hFF00, 1'($urandom_range(1)),
                          pick_key(), rand_sev(), 1'b1,
                          '{arcit_pkg::EV_FULL, 16'hFF00, 16'h0000, 6'd32, 6'd0, 1'b1});
                // re-raise of a present key still goes through when full
                pick = $urandom_range(TABLE_ENTRIES - 2);
                send_item(arcit_pkg::ACT_RAISE, fill_base + 16'(pick), 1'b1,
                          fill_base + 16'(pick + 1), rand_sev(), 1'b0, NO_GOLD);
                send_item(arcit_pkg::ACT_QUERY, 16'h0000, 1'b0, 16'h0000, 16'h0000,
                          1'b0, NO_GOLD);
            end

            budget = 0;
            while (budget < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 60)
                    run_cascade(budget);
                else
                    run_noise(budget);
            end

            // drain: hold the sender until every queued result has come back
            while (expected_events.size() != 0)
                @(posedge clk);
            // resume driving on a falling edge
            @(negedge clk);
        end

        // settle to catch stray results
        repeat (60) @(posedge clk);

        $display("Covered %0d transfers in and %0d results out over four handshake phases,",
                 items_accepted, results_checked);
        $display("with %0d table-full rejects, %0d symptom inhibits and %0d root clears.",
                 full_hits, inhibit_hits, release_hits);
        if (errors == 0 && expected_events.size() == 0)
        begin
            $display("alert_root_cause_inhibit_table_core: match");
        end
        else
        begin
            $display("alert_root_cause_inhibit_table_core: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/arcit_pkg.sv
hw/rtl/arcit_mem.sv
hw/rtl/arcit_scan.sv
hw/rtl/alert_root_cause_inhibit_table_core.sv
test/tb_alert_root_cause_inhibit_table_core.sv
